[design/reaction_time_trial_controller_macros.svh]
// ---------------------------------------------------------------------------
// Reaction timer assertion macros
// Shared concurrent assertion forms for the reaction timer checker.
// ---------------------------------------------------------------------------
`ifndef REACTION_TIME_TRIAL_CONTROLLER_MACROS_SVH
`define REACTION_TIME_TRIAL_CONTROLLER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define RTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[design/rtt_pkg.sv]
// ---------------------------------------------------------------------------
// Reaction timer package
// Widths, codes, types and helpers shared by the reaction timer modules.
// ---------------------------------------------------------------------------
package rtt_pkg;

  localparam int unsigned ActionW   = 2;
  localparam int unsigned WaitW     = 20;
  localparam int unsigned CountW    = 16;
  localparam int unsigned LedW      = 4;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned CfgIndexW = 1;

  localparam logic [CountW-1:0] RotateLimitRst  = CountW'(800);
  localparam logic [CountW-1:0] TimeoutLimitRst = CountW'(40000);
  localparam logic [CountW-1:0] CountMax        = '1;
  localparam logic [LedW-1:0]   AllLeds         = 4'hf;
  localparam logic [LedW-1:0]   FirstLed        = 4'h1;

  // Phase codes as they appear on the result
  localparam logic [PhaseW-1:0] PH_CODE_IDLE    = 3'd0;
  localparam logic [PhaseW-1:0] PH_CODE_ARMED   = 3'd1;
  localparam logic [PhaseW-1:0] PH_CODE_WAIT    = 3'd2;
  localparam logic [PhaseW-1:0] PH_CODE_RUN     = 3'd3;
  localparam logic [PhaseW-1:0] PH_CODE_TIMEOUT = 3'd4;
  localparam logic [PhaseW-1:0] PH_CODE_DONE    = 3'd5;
  localparam logic [PhaseW-1:0] PH_CODE_FALSE   = 3'd6;

  typedef enum logic [ActionW-1:0] {
    ACT_TICK = 2'd0,
    ACT_ARM  = 2'd1,
    ACT_ACK  = 2'd2
  } action_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_ROTATE_LIMIT  = 1'b0,
    REG_TIMEOUT_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_ARMED   = 7'b0000010,
    PH_WAIT    = 7'b0000100,
    PH_RUN     = 7'b0001000,
    PH_TIMEOUT = 7'b0010000,
    PH_DONE    = 7'b0100000,
    PH_FALSE   = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic               button;
    logic [WaitW-1:0]   wait_ticks;
  } item_t;

  typedef struct packed {
    logic [LedW-1:0]   leds;
    logic [PhaseW-1:0] phase;
    logic [CountW-1:0] response_ticks;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0] rotate_limit;
    logic [CountW-1:0] timeout_limit;
  } cfg_t;

  function automatic logic [PhaseW-1:0] phase_code(phase_e p);
    logic [PhaseW-1:0] code;
    unique case (p)
      PH_IDLE:    code = PH_CODE_IDLE;
      PH_ARMED:   code = PH_CODE_ARMED;
      PH_WAIT:    code = PH_CODE_WAIT;
      PH_RUN:     code = PH_CODE_RUN;
      PH_TIMEOUT: code = PH_CODE_TIMEOUT;
      PH_DONE:    code = PH_CODE_DONE;
      PH_FALSE:   code = PH_CODE_FALSE;
      default:    code = PH_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

[design/rtt_cfg_regs.sv]
// ---------------------------------------------------------------------------
// Reaction timer configuration registers
// Holds the rotate and timeout limits written over the config channel.
// ---------------------------------------------------------------------------
module rtt_cfg_regs import rtt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CountW-1:0]    cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROTATE_LIMIT:  cfg_d.rotate_limit  = cfg_data_i;
        REG_TIMEOUT_LIMIT: cfg_d.timeout_limit = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotate_limit  <= RotateLimitRst;
      cfg_q.timeout_limit <= TimeoutLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/rtt_core.sv]
// ---------------------------------------------------------------------------
// Reaction timer trial core
// Trial state and the one-pass update that applies one request to it.
// ---------------------------------------------------------------------------
module rtt_core import rtt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] rotate_count_q, rotate_count_d;
  logic [LedW-1:0]   rotate_pattern_q, rotate_pattern_d;
  logic [LedW-1:0]   led_q, led_d;
  logic [WaitW-1:0]  wait_count_q, wait_count_d;
  logic [WaitW-1:0]  wait_target_q, wait_target_d;
  logic [CountW-1:0] resp_count_q, resp_count_d;

  always_comb begin
    phase_d          = phase_q;
    rotate_count_d   = rotate_count_q;
    rotate_pattern_d = rotate_pattern_q;
    led_d            = led_q;
    wait_count_d     = wait_count_q;
    wait_target_d    = wait_target_q;
    resp_count_d     = resp_count_q;

    unique case (item_i.action)
      ACT_TICK: begin
        unique case (phase_q)
          PH_IDLE: begin
            if (rotate_count_q > cfg_i.rotate_limit) begin
              rotate_count_d   = '0;
              rotate_pattern_d = (rotate_pattern_q == '0) ? FirstLed
                                                          : {rotate_pattern_q[LedW-2:0], 1'b0};
              led_d            = rotate_pattern_d;
            end else begin
              rotate_count_d = rotate_count_q + 1'b1;
            end
          end
          PH_ARMED: begin
            wait_count_d = '0;
            resp_count_d = '0;
            led_d        = '0;
            phase_d      = PH_WAIT;
          end
          PH_WAIT: begin
            wait_count_d = wait_count_q + 1'b1;
            if (item_i.button) begin
              phase_d = PH_FALSE;
            end else if (wait_count_d >= wait_target_q) begin
              led_d   = AllLeds;
              phase_d = PH_RUN;
            end
          end
          PH_RUN: begin
            // saturate the reaction count
            if (resp_count_q != CountMax) begin
              resp_count_d = resp_count_q + 1'b1;
            end
            if (item_i.button) begin
              led_d   = '0;
              phase_d = PH_DONE;
            end else if (resp_count_d > cfg_i.timeout_limit) begin
              led_d   = '0;
              phase_d = PH_TIMEOUT;
            end
          end
          default: ;
        endcase
      end
      ACT_ARM: begin
        wait_target_d = item_i.wait_ticks;
        phase_d       = PH_ARMED;
      end
      ACT_ACK: begin
        phase_d = PH_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_IDLE;
      rotate_count_q   <= '0;
      rotate_pattern_q <= '0;
      led_q            <= '0;
      wait_count_q     <= '0;
      wait_target_q    <= '0;
      resp_count_q     <= '0;
    end else if (step_i) begin
      phase_q          <= phase_d;
      rotate_count_q   <= rotate_count_d;
      rotate_pattern_q <= rotate_pattern_d;
      led_q            <= led_d;
      wait_count_q     <= wait_count_d;
      wait_target_q    <= wait_target_d;
      resp_count_q     <= resp_count_d;
    end
  end

  assign res_o.leds           = led_d;
  assign res_o.phase          = phase_code(phase_d);
  assign res_o.response_ticks = resp_count_d;

endmodule

[design/reaction_time_trial_controller.sv]
// Path: input register, then result register; a stalled result holds requests.
// Throughput: one request per cycle while the result channel is not stalled;
//   the input register and the result register let a new request in while
//   a finished result waits. The core's one-pass state update sets the rate.
// Reset: rst_ni low clears both stages and the trial state at once;
//   the limits return to 800 and 40000.
// ---------------------------------------------------------------------------
// Reaction timer top level
// Input register, trial core, result register and configuration registers.
// ---------------------------------------------------------------------------
module reaction_time_trial_controller import rtt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ActionW-1:0]   action_i,
  input  logic                 button_i,
  input  logic [WaitW-1:0]     wait_ticks_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LedW-1:0]      leds_o,
  output logic [PhaseW-1:0]    phase_o,
  output logic [CountW-1:0]    response_ticks_o,
  // configuration channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CountW-1:0]    cfg_data_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q, item_valid_d;
  result_t res_next;
  result_t res_q;
  logic    out_valid_q, out_valid_d;
  logic    in_fire;
  logic    advance;
  logic    step;

  rtt_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The held request moves on whenever the result register is free or
  // is being emptied in this cycle.
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = item_valid_q && advance;
  assign in_ready_o = !item_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_fire) begin
      item_valid_d = 1'b1;
    end else if (advance) begin
      item_valid_d = 1'b0;
    end
  end

  // Hold the request payload; it needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.action     <= action_i;
      item_q.button     <= button_i;
      item_q.wait_ticks <= wait_ticks_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  // Apply the held request to the trial state in one pass.
  rtt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_next)
  );

  // Result register: load on a step, drop the valid when the result is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign leds_o           = res_q.leds;
  assign phase_o          = res_q.phase;
  assign response_ticks_o = res_q.response_ticks;

endmodule

[design/rtt_checker.sv]
// ---------------------------------------------------------------------------
// Reaction timer port checker
// Watches the top level ports over time; bound to the top level below.
// ---------------------------------------------------------------------------
`include "reaction_time_trial_controller_macros.svh"

module rtt_checker import rtt_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [LedW-1:0]      leds_o,
  input logic [PhaseW-1:0]    phase_o,
  input logic [CountW-1:0]    response_ticks_o
);

  logic                          stalled;
  logic [LedW+PhaseW+CountW-1:0] shown;
  logic                          dark_phase;

  assign stalled    = out_valid_o && !out_ready_i;
  assign shown      = {leds_o, phase_o, response_ticks_o};
  assign dark_phase = (phase_o == PH_CODE_WAIT) || (phase_o == PH_CODE_TIMEOUT) ||
                      (phase_o == PH_CODE_DONE) || (phase_o == PH_CODE_FALSE);

  `RTT_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |-> out_valid_o !== 1'b1, "result valid in reset")

  `RTT_ASSERT(a_stall_hold, stalled |=> out_valid_o && $stable(shown), "stalled result changed")

  `RTT_ASSERT(a_run_leds_on, out_valid_o && phase_o == PH_CODE_RUN |-> leds_o == AllLeds, "LEDs off")

  `RTT_ASSERT(a_dark_phases, out_valid_o && dark_phase |-> leds_o == '0, "LEDs lit when dark")

  `RTT_ASSERT(a_wait_no_count, out_valid_o && phase_o == PH_CODE_WAIT |-> response_ticks_o == '0, "count moved")

endmodule

bind reaction_time_trial_controller rtt_checker u_rtt_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Reaction timer testbench
// Sends tick, arm, acknowledge and unused requests with random gaps and result
// stalls. Predicts each result in a scoreboard and compares every field.
// ---------------------------------------------------------------------------
module tb_top;
  import rtt_pkg::*;

  // Action code 3 has no meaning; the block must leave its state alone.
  localparam logic [ActionW-1:0] ActUnused = 2'd3;
  localparam int unsigned RequestsPerSetting = 140;
  localparam int unsigned PlanLen = 7;
  localparam cfg_t LimitPlan [PlanLen] = '{
    '{16'd65534, 16'd65534},
    '{16'd2,     16'd5},
    '{16'd1,     16'd40},
    '{16'd3,     16'd12},
    '{16'd0,     16'd65534},
    '{16'd65534, 16'd1},
    '{16'd0,     16'd1}
  };

  // Track the trial state, hold the expected results in arrival order.
  class trial_scoreboard;
    logic [CountW-1:0] rotate_limit;
    logic [CountW-1:0] timeout_limit;
    logic [PhaseW-1:0] trial_phase;
    logic [CountW-1:0] rotate_count;
    logic [LedW-1:0]   rotate_pattern;
    logic [LedW-1:0]   led_state;
    logic [WaitW-1:0]  wait_count;
    logic [WaitW-1:0]  wait_target;
    logic [CountW-1:0] response_count;
    result_t           readout_q[$];
    int                failures;

    function new();
      rotate_limit   = RotateLimitRst;
      timeout_limit  = TimeoutLimitRst;
      trial_phase    = PH_CODE_IDLE;
      rotate_count   = '0;
      rotate_pattern = '0;
      led_state      = '0;
      wait_count     = '0;
      wait_target    = '0;
      response_count = '0;
      failures       = 0;
    endfunction

    function void set_limit(cfg_reg_e index, logic [CountW-1:0] value);
      case (index)
        REG_ROTATE_LIMIT:  rotate_limit = value;
        REG_TIMEOUT_LIMIT: timeout_limit = value;
        default: ;
      endcase
    endfunction

    // Apply one accepted request and queue the readout it produces.
    function void note_request(item_t req);
      result_t outcome;
      case (req.action)
        ACT_TICK: begin
          case (trial_phase)
            PH_CODE_IDLE: begin
              if (rotate_count > rotate_limit) begin
                rotate_count   = '0;
                rotate_pattern = (rotate_pattern == '0) ? FirstLed : rotate_pattern << 1;
                led_state      = rotate_pattern;
              end else begin
                rotate_count = rotate_count + CountW'(1);
              end
            end
            PH_CODE_ARMED: begin
              wait_count     = '0;
              response_count = '0;
              led_state      = '0;
              trial_phase    = PH_CODE_WAIT;
            end
            PH_CODE_WAIT: begin
              wait_count = wait_count + WaitW'(1);
              // a press wins even on the tick that reaches the delay
              if (req.button) begin
                trial_phase = PH_CODE_FALSE;
              end else if (wait_count >= wait_target) begin
                led_state   = AllLeds;
                trial_phase = PH_CODE_RUN;
              end
            end
            PH_CODE_RUN: begin
              if (response_count != CountMax) response_count++;
              // a press wins over a timeout on the same tick
              if (req.button) begin
                led_state   = '0;
                trial_phase = PH_CODE_DONE;
              end else if (response_count > timeout_limit) begin
                led_state   = '0;
                trial_phase = PH_CODE_TIMEOUT;
              end
            end
            default: ;
          endcase
        end
        ACT_ARM: begin
          wait_target = req.wait_ticks;
          trial_phase = PH_CODE_ARMED;
        end
        ACT_ACK: trial_phase = PH_CODE_IDLE;
        default: ;
      endcase
      outcome.leds           = led_state;
      outcome.phase          = trial_phase;
      outcome.response_ticks = response_count;
      readout_q.push_back(outcome);
    endfunction

    function void check_readout(result_t got);
      result_t want;
      if (readout_q.size() == 0) begin
        failures++;
        $display("%0t: unexpected result leds %h phase %0d ticks %0d", $time,
                 got.leds, got.phase, got.response_ticks);
        return;
      end
      want = readout_q.pop_front();
      if (got.leds !== want.leds) begin
        failures++;
        $display("%0t: leds expected %h, actual %h", $time, want.leds, got.leds);
      end
      if (got.phase !== want.phase) begin
        failures++;
        $display("%0t: phase expected %0d, actual %0d", $time, want.phase, got.phase);
      end
      if (got.response_ticks !== want.response_ticks) begin
        failures++;
        $display("%0t: response_ticks expected %0d, actual %0d", $time,
                 want.response_ticks, got.response_ticks);
      end
    endfunction

    function int pending();
      return readout_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [ActionW-1:0]   action_i;
  logic                 button_i;
  logic [WaitW-1:0]     wait_ticks_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [LedW-1:0]      leds_o;
  logic [PhaseW-1:0]    phase_o;
  logic [CountW-1:0]    response_ticks_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CountW-1:0]    cfg_data_i;

  trial_scoreboard sbd;
  int unsigned     requests_counted;
  bit              send_burst;
  bit              sink_burst;

  reaction_time_trial_controller dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .button_i         (button_i),
    .wait_ticks_i     (wait_ticks_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .leds_o           (leds_o),
    .phase_o          (phase_o),
    .response_ticks_o (response_ticks_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Present one request after a random gap, hold it until accepted.
  task automatic send_request(logic [ActionW-1:0] action, logic button,
                              logic [WaitW-1:0] wait_ticks);
    item_t req;
    int    gap;
    req.action     = action;
    req.button     = button;
    req.wait_ticks = wait_ticks;
    if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= req.action;
    button_i     <= req.button;
    wait_ticks_i <= req.wait_ticks;
    do @(posedge clk_i); while (!in_ready_o);
    sbd.note_request(req);
    if (action != ActUnused) requests_counted++;
  endtask

  // Drop the request line and let every expected result come out.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sbd.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e index, logic [CountW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sbd.set_limit(index, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One trial: a few idle ticks, an arm, ticks with random presses and
  // occasional stray commands, then an acknowledge.
  task automatic run_trial();
    logic [WaitW-1:0] delay;
    int               press_odds;
    int               trial_ticks;
    repeat ($urandom_range(0, 6))
      send_request(ACT_TICK, 1'($urandom_range(0, 1)), WaitW'($urandom));
    delay = ($urandom_range(0, 9) == 0) ? WaitW'($urandom) : WaitW'($urandom_range(0, 10));
    send_request(ACT_ARM, 1'($urandom_range(0, 1)), delay);
    press_odds  = $urandom_range(3, 40);
    trial_ticks = $urandom_range(2, 50);
    repeat (trial_ticks) begin
      case ($urandom_range(0, 49))
        0: send_request(ACT_ARM, 1'($urandom_range(0, 1)), WaitW'($urandom_range(0, 6)));
        1: send_request(ACT_ACK, 1'($urandom_range(0, 1)), WaitW'($urandom));
        2: send_request(ActUnused, 1'($urandom_range(0, 1)), WaitW'($urandom));
        default: send_request(ACT_TICK, $urandom_range(0, press_odds - 1) == 0,
                              WaitW'($urandom));
      endcase
    end
    send_request(ACT_ACK, 1'($urandom_range(0, 1)), WaitW'($urandom));
  endtask

  initial begin : stimulus
    int unsigned stop_at;
    sbd              = new();
    requests_counted = 0;
    send_burst       = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    action_i         = ACT_TICK;
    button_i         = 1'b0;
    wait_ticks_i     = '0;
    out_ready_i      = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = REG_ROTATE_LIMIT;
    cfg_data_i       = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed requests at the reset limits.
    send_request(ACT_TICK, 1'b1, 20'hfffff);   // idle ignores the button
    send_request(ActUnused, 1'b1, 20'hfffff);
    send_request(ACT_ARM, 1'b1, '0);           // zero delay
    send_request(ACT_TICK, 1'b0, '0);
    send_request(ACT_TICK, 1'b0, '0);          // stimulus on first wait tick
    send_request(ACT_TICK, 1'b0, '0);
    send_request(ACT_TICK, 1'b1, '0);          // press ends the trial
    send_request(ACT_TICK, 1'b1, '0);          // done holds
    send_request(ACT_ACK, 1'b0, '0);
    send_request(ACT_ARM, 1'b0, 20'd3);
    repeat (3) send_request(ACT_TICK, 1'b0, '0);
    send_request(ACT_TICK, 1'b1, '0);          // press on the stimulus tick
    send_request(ACT_ARM, 1'b0, 20'hfffff);    // re-arm from a false start
    send_request(ACT_TICK, 1'b0, '0);
    send_request(ACT_ACK, 1'b0, '0);

    // Directed requests at the tightest limits: rotation and timeout.
    drain_results();
    write_register(REG_ROTATE_LIMIT, 16'd0);
    write_register(REG_TIMEOUT_LIMIT, 16'd1);
    repeat (2) send_request(ACT_TICK, 1'b0, '0);
    send_request(ACT_ARM, 1'b0, '0);
    repeat (3) send_request(ACT_TICK, 1'b0, '0);
    send_request(ACT_TICK, 1'b1, '0);          // press on the timeout tick
    send_request(ACT_ARM, 1'b0, '0);
    repeat (4) send_request(ACT_TICK, 1'b0, '0);
    send_request(ACT_ACK, 1'b0, '0);

    // Random trials, one batch per limit setting.
    for (int p = 0; p < PlanLen; p++) begin
      drain_results();
      write_register(REG_ROTATE_LIMIT, LimitPlan[p].rotate_limit);
      write_register(REG_TIMEOUT_LIMIT, LimitPlan[p].timeout_limit);
      stop_at = requests_counted + RequestsPerSetting;
      while (requests_counted < stop_at) run_trial();
    end

    drain_results();
    if (sbd.failures == 0 && sbd.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Take results with random stalls and check each one.
  initial begin : result_sink
    result_t got;
    int      stall;
    sink_burst = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 29) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, 4);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.leds           = leds_o;
      got.phase          = phase_o;
      got.response_ticks = response_ticks_o;
      sbd.check_readout(got);
    end
  end

  initial begin : watchdog
    #(2_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
